### sv/resampling_voice_mixer_defines.svh
// ---------------------------------------------------------------------------
// resampling_voice_mixer_defines
// assertion macros for the resampling voice mixer
// ---------------------------------------------------------------------------
`ifndef RESAMPLING_VOICE_MIXER_DEFINES_SVH
`define RESAMPLING_VOICE_MIXER_DEFINES_SVH
// property that must hold while out of reset
`define RVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define RVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/rvm_pkg.sv
// ---------------------------------------------------------------------------
// rvm_pkg
// shared constants and types of the resampling voice mixer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rvm_pkg;
  localparam int DefVoices = 4;
  localparam int DefMemDepth = 65536;
  localparam logic [15:0] DefEngineRate = 16'd11025;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MIX = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;
  typedef struct packed {
    logic start;
    logic [33:0] dividend;
    logic [15:0] divisor;
  } div_req_t;
  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] quotient;
  } div_stat_t;
endpackage

### sv/rvm_divider.sv
// ---------------------------------------------------------------------------
// rvm_divider
// restoring radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resampling_voice_mixer_defines.svh"
module rvm_divider import rvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);
  logic [33:0] quo;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic [16:0] sub;
  always_comb begin
    trial = {rem[15:0], quo[33]};
    sub = trial - {1'b0, dvs};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd34;
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= sub;
          quo <= {quo[32:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[32:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quotient = quo[31:0];
  `RVM_ASSERT_NEXT(a_div_done_once, done, !done, "divider done held two cycles")
  `RVM_ASSERT(a_div_count, !busy || cnt != 6'd0, "divider busy with zero count")
  `RVM_ASSERT_NEXT(a_div_start, req.start, busy, "divider did not start")
endmodule

### sv/resampling_voice_mixer.sv
// ---------------------------------------------------------------------------
// resampling_voice_mixer
// multi-voice 8-bit pcm mixer with 16.16 resampling positions
// ---------------------------------------------------------------------------
// channel   dir  signals
// s_axis    in   tvalid tready tdata tuser (request item)
// m_axis    out  tvalid tready tdata (result item)
// cfg       in   cfg_we cfg_data (engine rate)
// a start item waits for its step from the radix-2 step divider
// a mix item visits each voice in turn, one shared memory read port and adder
// write and stop items go straight to the result; a result is held until taken
// rst is synchronous; voices come up idle, sample memory is undefined
// s_axis_tready is low while an item is at work or a result waits
`timescale 1ns / 1ps
`include "resampling_voice_mixer_defines.svh"
module resampling_voice_mixer import rvm_pkg::*; #(
  parameter int VOICES = DefVoices,
  parameter int VOICE_MEM_DEPTH = DefMemDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // source_rate, sample_count, voice_index, sample_index, frame_data,
  // mix_in, zero fill
  input  logic [95:0] s_axis_tdata,
  // operation, frame_is_16bit, frame_is_stereo, zero fill
  input  logic [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mix_out, chosen_voice, active_voices, zero fill
  output logic [15:0] m_axis_tdata
);
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(VOICE_MEM_DEPTH);
  localparam int MW = VW + AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV = 3'd1;
  localparam logic [2:0] S_MRD = 3'd2;
  localparam logic [2:0] S_MADD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_DWAIT = 3'd5;

  logic [2:0] state;
  logic [15:0] engine_rate;
  logic [31:0] pos [VOICES];
  logic [31:0] step [VOICES];
  logic [15:0] len [VOICES];
  logic [VOICES-1:0] active;
  logic [7:0] mem [VOICES*VOICE_MEM_DEPTH];
  logic [7:0] rd_data;
  logic [MW-1:0] rd_addr;
  logic [VW-1:0] slot;
  logic [VW-1:0] vcur;
  logic [8:0] acc;
  logic [7:0] mix_out;
  logic [1:0] chosen;
  logic [15:0] req_len;
  logic hit;

  logic [1:0] op;
  logic [17:0] src_rate;
  logic [15:0] cnt_in;
  logic [1:0] vi;
  logic [15:0] si;
  logic [31:0] fd;
  logic f16, fst;
  logic [7:0] mix_in;
  assign op = s_axis_tuser[1:0];
  assign f16 = s_axis_tuser[2];
  assign fst = s_axis_tuser[3];
  assign src_rate = s_axis_tdata[17:0];
  assign cnt_in = s_axis_tdata[33:18];
  assign vi = s_axis_tdata[35:34];
  assign si = s_axis_tdata[51:36];
  assign fd = s_axis_tdata[83:52];
  assign mix_in = s_axis_tdata[91:84];

  div_req_t dreq;
  div_stat_t dstat;
  rvm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .stat(dstat));

  logic [15:0] er;
  logic [17:0] rate_eff;
  logic [VW-1:0] free_slot;
  logic [8:0] fa, fb, fs;
  logic [7:0] conv;
  logic wr_ok;
  always_comb begin
    er = (engine_rate == 16'd0) ? DefEngineRate : engine_rate;
    rate_eff = (src_rate == 18'd0) ? {2'b0, er} : src_rate;
    free_slot = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active[v]) free_slot = VW'(v);
    end
    if (f16) begin
      fa = {1'b0, fd[15:8] ^ 8'h80};
      fb = {1'b0, fd[31:24] ^ 8'h80};
    end else begin
      fa = {1'b0, fd[7:0]};
      fb = {1'b0, fd[15:8]};
    end
    fs = fa + fb;
    conv = fst ? fs[8:1] : fa[7:0];
    wr_ok = (32'(vi) < 32'(VOICES)) && (32'(si) < 32'(VOICE_MEM_DEPTH));
    dreq.start = (state == S_IDLE) && s_axis_tvalid && (op == OP_START);
    dreq.dividend = {rate_eff, 16'd0};
    dreq.divisor = er;
  end

  // voice sample write and read, one shared read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid && op == OP_WRITE && wr_ok) begin
      mem[{vi[VW-1:0], si[AW-1:0]}] <= conv;
    end
    rd_data <= mem[rd_addr];
  end
  assign rd_addr = {vcur, pos[vcur][16 +: AW]};

  logic signed [9:0] sum;
  always_comb begin
    sum = $signed({1'b0, acc}) + $signed({2'b0, rd_data}) - 10'sd128;
    hit = active[vcur] && ({16'd0, pos[vcur][31:16]} < {16'd0, len[vcur]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      engine_rate <= DefEngineRate;
      active <= '0;
      for (int v = 0; v < VOICES; v++) begin
        pos[v] <= '0;
        step[v] <= '0;
        len[v] <= '0;
      end
    end else begin
      if (cfg_we) engine_rate <= cfg_data;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mix_out <= 8'd0;
            chosen <= 2'd0;
            case (op)
              OP_START: begin
                slot <= free_slot;
                req_len <= cnt_in;
                state <= S_DIV;
              end
              OP_MIX: begin
                acc <= {1'b0, mix_in};
                vcur <= '0;
                state <= S_MRD;
              end
              OP_STOP: begin
                active <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (dstat.done) begin
            step[slot] <= (dstat.quotient == 32'd0) ? 32'd1 : dstat.quotient;
            pos[slot] <= '0;
            len[slot] <= req_len;
            active[slot] <= 1'b1;
            chosen <= 2'(slot);
            state <= S_OUT;
          end
        end
        S_MRD: state <= S_MADD;
        S_MADD: begin
          if (hit) begin
            // acc holds value+128, saturate to 0..255
            if (sum > 10'sd255) acc <= 9'd255;
            else if (sum < 10'sd0) acc <= 9'd0;
            else acc <= sum[8:0];
            pos[vcur] <= pos[vcur] + step[vcur];
          end else if (active[vcur]) begin
            active[vcur] <= 1'b0;
          end
          if (32'(vcur) == VOICES - 1) begin
            mix_out <= hit ? ((sum > 10'sd255) ? 8'd255 : (sum < 10'sd0) ? 8'd0 :
                               sum[7:0]) : acc[7:0];
            state <= S_OUT;
          end else begin
            vcur <= vcur + VW'(1);
            state <= S_MRD;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [3:0] amask;
  always_comb begin
    amask = '0;
    for (int v = 0; v < VOICES && v < 4; v++) amask[v] = active[v];
  end
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {2'b00, amask, chosen, mix_out};

  `RVM_ASSERT(a_ready_valid, !(s_axis_tready && m_axis_tvalid), "ready while result waits")
  `RVM_ASSERT_NEXT(a_stop, s_axis_tvalid && s_axis_tready && op == OP_STOP, active == '0,
    "stop left a voice active")
  `RVM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
    "result changed while stalled")
endmodule

### verif/resampling_voice_mixer_test.sv
// ---------------------------------------------------------------------------
// resampling_voice_mixer_test
// self-checking bench: stream items with random bursts and output stalls,
// predict each result item and compare field by field in a scoreboard
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module resampling_voice_mixer_test;
  import rvm_pkg::*;

  localparam int NVOICE = 4;
  localparam int DEPTH = 65536;
  localparam logic [15:0] FALLBACK_RATE = 16'd11025;

  // request item fields, split over tdata and tuser when driven
  typedef struct packed {
    logic [7:0]  mix_in;
    logic        stereo;
    logic        wide;
    logic [31:0] frame;
    logic [15:0] sidx;
    logic [1:0]  vidx;
    logic [15:0] count;
    logic [17:0] rate;
    logic [1:0]  op;
  } req_t;

  typedef struct packed {
    logic [1:0] fill;
    logic [3:0] active;
    logic [1:0] chosen;
    logic [7:0] mix;
  } res_t;

  class mixer_scoreboard;
    logic [15:0] engine_rate;
    logic [31:0] pos [NVOICE];
    logic [31:0] stp [NVOICE];
    logic [15:0] len [NVOICE];
    bit          act [NVOICE];
    logic [7:0]  mem [NVOICE][DEPTH];
    bit          wr [NVOICE][DEPTH];
    res_t        expected_q[$];
    int          errors;
    int          n_in;
    int          n_checked;
    int          n_op [4];

    function new();
      engine_rate = FALLBACK_RATE;
      for (int v = 0; v < NVOICE; v++) begin
        pos[v] = 0; stp[v] = 0; len[v] = 0; act[v] = 0;
      end
    endfunction

    function void note_input(req_t r);
      res_t e;
      logic [15:0] er;
      logic [63:0] rate;
      logic [31:0] step;
      int slot, acc, idx;
      logic [8:0] a, b;
      e = '0;
      n_in++;
      n_op[r.op]++;
      case (r.op)
        OP_START: begin
          slot = 0;
          for (int v = NVOICE - 1; v >= 0; v--) if (!act[v]) slot = v;
          er = engine_rate ? engine_rate : FALLBACK_RATE;
          rate = r.rate ? 64'(r.rate) : 64'(er);
          step = 32'((rate << 16) / er);
          if (step == 0) step = 1;
          len[slot] = r.count; pos[slot] = 0; stp[slot] = step; act[slot] = 1;
          e.chosen = slot[1:0];
        end
        OP_WRITE: begin
          if (!r.wide) begin
            a = r.frame[7:0]; b = r.frame[15:8];
          end else begin
            a = r.frame[15:8] ^ 8'h80; b = r.frame[31:24] ^ 8'h80;
          end
          mem[r.vidx][r.sidx] = r.stereo ? 8'((a + b) >> 1) : a[7:0];
          wr[r.vidx][r.sidx] = 1;
        end
        OP_MIX: begin
          acc = int'(r.mix_in) - 128;
          for (int v = 0; v < NVOICE; v++) begin
            if (act[v]) begin
              idx = int'(pos[v] >> 16);
              if (idx >= len[v]) act[v] = 0;
              else begin
                acc += int'(mem[v][idx % DEPTH]) - 128;
                if (acc > 127) acc = 127;
                if (acc < -128) acc = -128;
                pos[v] += stp[v];
              end
            end
          end
          e.mix = 8'(acc + 128);
        end
        default: for (int v = 0; v < NVOICE; v++) act[v] = 0;
      endcase
      for (int v = 0; v < NVOICE; v++) e.active[v] = act[v];
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t r);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", r);
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (r.mix !== e.mix || r.chosen !== e.chosen || r.active !== e.active
          || r.fill !== e.fill) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: mix %h/%h voice %0d/%0d active %b/%b",
                   n_checked, e.mix, r.mix, e.chosen, r.chosen, e.active, r.active);
      end
    endfunction

    // finds a sample the next mix item would read without it ever being written
    function bit unread_gap(output int voice, output int idx);
      for (int v = 0; v < NVOICE; v++) begin
        idx = int'(pos[v] >> 16);
        if (act[v] && idx < len[v] && !wr[v][idx % DEPTH]) begin
          voice = v; idx = idx % DEPTH;
          return 1;
        end
      end
      return 0;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [7:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [15:0]  m_axis_tdata;

  mixer_scoreboard sb = new();
  int burst_left = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_cycles = 0;

  always #5 clk = ~clk;

  resampling_voice_mixer dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // receiver: shifting stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (!hold_done && sb.n_in >= 200) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cycles = $urandom_range(20, 120);
      end else mode_cycles--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(req_t r);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, r.mix_in, r.frame, r.sidx, r.vidx, r.count, r.rate};
    s_axis_tuser <= {4'b0, r.stereo, r.wide, r.op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(r);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end else burst_left--;
  endtask

  function automatic req_t noise();
    req_t r;
    r = {$urandom, $urandom, $urandom};
    return r;
  endfunction

  task automatic write_frame(int v, int idx);
    req_t r;
    r = noise();
    r.op = OP_WRITE; r.vidx = 2'(v); r.sidx = 16'(idx);
    send(r);
  endtask

  task automatic start_voice(logic [17:0] rate, logic [15:0] count);
    req_t r;
    r = noise();
    r.op = OP_START; r.rate = rate; r.count = count;
    send(r);
  endtask

  // any sample a mix would read gets written first
  task automatic mix(logic [7:0] level);
    req_t r;
    int v, idx;
    while (sb.unread_gap(v, idx)) write_frame(v, idx);
    r = noise();
    r.op = OP_MIX; r.mix_in = level;
    send(r);
  endtask

  task automatic stop_all();
    req_t r;
    r = noise();
    r.op = OP_STOP;
    send(r);
  endtask

  task automatic set_engine_rate(logic [15:0] value);
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.engine_rate = value;
  endtask

  task automatic random_phase(int n);
    int pick;
    logic [15:0] count;
    logic [17:0] rate;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        write_frame($urandom_range(0, 3),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 63));
      end else if (pick < 40) begin
        case ($urandom_range(0, 9))
          0: count = 0;
          1: count = 16'($urandom_range(0, 65535));
          default: count = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
          0: rate = 0;
          1: rate = 18'($urandom_range(0, 262143));
          default: rate = 18'($urandom_range(1,
                             3 * (sb.engine_rate ? sb.engine_rate : 11025)));
        endcase
        start_voice(rate, count);
      end else if (pick < 95) mix(8'($urandom_range(0, 255)));
      else stop_all();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: frame formats at extremes, start edge cases, every operation
    send('{mix_in: 0, stereo: 0, wide: 0, frame: 32'h0000_00ff, sidx: 0,
           vidx: 0, count: 0, rate: 0, op: OP_WRITE});
    send('{mix_in: 0, stereo: 1, wide: 0, frame: 32'h0000_ff01, sidx: 1,
           vidx: 0, count: 0, rate: 0, op: OP_WRITE});
    send('{mix_in: 0, stereo: 0, wide: 1, frame: 32'h0000_8000, sidx: 0,
           vidx: 1, count: 0, rate: 0, op: OP_WRITE});
    send('{mix_in: 0, stereo: 1, wide: 1, frame: 32'hffff_7fff, sidx: 0,
           vidx: 2, count: 0, rate: 0, op: OP_WRITE});
    send('{mix_in: 8'hff, stereo: 1, wide: 1, frame: 32'hffff_ffff,
           sidx: 16'hffff, vidx: 3, count: 16'hffff, rate: 18'h3ffff, op: OP_WRITE});
    write_frame(3, 0);
    start_voice(0, 2);
    start_voice(18'h3ffff, 1);
    start_voice(1, 0);
    start_voice(22050, 3);
    start_voice(11025, 1);
    mix(8'hff);
    mix(8'h00);
    mix(8'h80);
    mix(8'hff);
    stop_all();
    mix(8'h7f);

    set_engine_rate(16'd11025);
    random_phase(90);
    set_engine_rate(16'd1);
    random_phase(45);
    set_engine_rate(16'hffff);
    random_phase(65);
    set_engine_rate(16'd0);
    random_phase(40);
    set_engine_rate(16'($urandom_range(2000, 48000)));
    random_phase(80);

    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items: %0d starts, %0d writes, %0d mixes, %0d stops",
             sb.n_in, sb.n_op[OP_START], sb.n_op[OP_WRITE], sb.n_op[OP_MIX],
             sb.n_op[OP_STOP]);
    $display("engine rates 11025, 1, 65535, 0 and one random; %0d results checked, %0d bad",
             sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/rvm_pkg.sv
sv/rvm_divider.sv
sv/resampling_voice_mixer.sv
verif/resampling_voice_mixer_test.sv
